[design/ribi_pkg.sv]
package ribi_pkg;

   // Ring size is set by CAPACITY; the slot index width is derived from it.
   localparam int CAPACITY = 16;
   localparam int PTR_W    = $clog2(CAPACITY);
   localparam int CNT_W    = 5;
   localparam int DATA_W   = 8;
   localparam int STATUS_W = 2;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

   localparam logic [CNT_W-1:0] STEP_UP  = CNT_W'(1);
   localparam logic [CNT_W-1:0] STEP_DN  = CNT_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

   typedef struct packed {
      logic              rd_en;
      logic [PTR_W-1:0]  rd_addr;
      logic              wr_en;
      logic [PTR_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
   } mem_req_type;

   // Slot address plus an offset of at most CAPACITY, wrapped round the ring.
   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] n);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(p) + (CNT_W+1)'(n);
      if (s >= (CNT_W+1)'(CAPACITY)) begin
         s = s - (CNT_W+1)'(CAPACITY);
      end
      return s[PTR_W-1:0];
   endfunction

endpackage

[design/ribi_req_if.sv]
interface ribi_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [ribi_pkg::CNT_W-1:0]    index;
   logic [ribi_pkg::DATA_W-1:0]   value;

   modport source (output valid, func, index, value, input ready);
   modport sink   (input valid, func, index, value, output ready);
endinterface

[design/ribi_rsp_if.sv]
interface ribi_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ribi_pkg::DATA_W-1:0]   removed_value;
   logic [ribi_pkg::STATUS_W-1:0] status;
   logic [ribi_pkg::CNT_W-1:0]    count_after;

   modport source (output valid, removed_value, status, count_after, input ready);
   modport sink   (input valid, removed_value, status, count_after, output ready);
endinterface

[design/ring_buffer_indexed_insert_remove_top.sv]
// Ring of CAPACITY bytes with insert and remove at a logical index.
// req_chan carries one request: func (insert or remove), index counted from
// the head, and the byte to insert. rsp_chan returns exactly one response per
// request: the removed byte (zero unless a remove succeeded), a status (ok,
// full, empty, index out of range) and the element count afterwards.
// Both channels use valid/ready; a request is taken when both are high.
// The block works on one request at a time. A request moves m slots. The
// side to shift is picked by comparing the index with half the number of
// bytes that stay in the ring, so m is at most CAPACITY/2. The slot store has
// one read and one write port with a registered read: one slot moves per
// cycle, and the last write drains after the final read. Failed requests
// touch nothing. The input is ready again in the same cycle as a response
// appears. The response sits in an output register; the next request is
// accepted while it waits, and that request's response is held back until
// the receiver takes the earlier one. Reset clears head and count at once;
// slot contents are not cleared and are never read before being written.
module ring_buffer_indexed_insert_remove_top (
   input logic        clock,
   input logic        reset,
   ribi_req_if.sink   req_chan,
   ribi_rsp_if.source rsp_chan
);

   ribi_pkg::mem_req_type       mem_req;
   logic [ribi_pkg::DATA_W-1:0] rd_data;

   ribi_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .mem_req  (mem_req),
      .rd_data  (rd_data)
   );

   ribi_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

[design/ribi_mem.sv]
module ribi_mem (
   input  logic                        clock,
   input  ribi_pkg::mem_req_type       mem_req,
   output logic [ribi_pkg::DATA_W-1:0] rd_data
);

   logic [ribi_pkg::DATA_W-1:0] slot_mem [ribi_pkg::CAPACITY];
   logic [ribi_pkg::DATA_W-1:0] rd_data_ff;

   // Read-first: a read returns the entry as it stood before this cycle's write.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         slot_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= slot_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/ribi_ctrl.sv]
module ribi_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   ribi_req_if.sink                    req_chan,
   ribi_rsp_if.source                  rsp_chan,
   output ribi_pkg::mem_req_type       mem_req,
   input  logic [ribi_pkg::DATA_W-1:0] rd_data
);

   localparam int PTR_W    = ribi_pkg::PTR_W;
   localparam int CNT_W    = ribi_pkg::CNT_W;
   localparam int DATA_W   = ribi_pkg::DATA_W;
   localparam int STATUS_W = ribi_pkg::STATUS_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MOVE  = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic [1:0]          state_ff,     state_in;
   logic [PTR_W-1:0]    head_ff,      head_in;
   logic [CNT_W-1:0]    count_ff,     count_in;
   logic [PTR_W-1:0]    rd_ptr_ff,    rd_ptr_in;
   logic [CNT_W-1:0]    rd_left_ff,   rd_left_in;
   logic                dir_dn_ff,    dir_dn_in;
   logic                pend_ff,      pend_in;
   logic [PTR_W-1:0]    pend_addr_ff, pend_addr_in;
   logic                cap_ff,       cap_in;
   logic                fin_wr_ff,    fin_wr_in;
   logic [PTR_W-1:0]    fin_addr_ff,  fin_addr_in;
   logic [DATA_W-1:0]   value_ff,     value_in;
   logic [DATA_W-1:0]   removed_ff,   removed_in;
   logic [STATUS_W-1:0] status_ff,    status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_rm_ff,    rsp_rm_in;
   logic [STATUS_W-1:0] rsp_st_ff,    rsp_st_in;
   logic [CNT_W-1:0]    rsp_cnt_ff,   rsp_cnt_in;

   logic [CNT_W-1:0]    idx;
   logic [CNT_W-1:0]    cnt_m1;
   logic [PTR_W-1:0]    head_idx;
   logic [PTR_W-1:0]    head_dn;
   logic                rsp_free;

   assign idx      = req_chan.index;
   assign cnt_m1   = count_ff - ribi_pkg::STEP_UP;
   assign head_idx = ribi_pkg::ptr_add(head_ff, idx);
   assign head_dn  = ribi_pkg::ptr_add(head_ff, ribi_pkg::STEP_DN);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.removed_value = rsp_rm_ff;
   assign rsp_chan.status        = rsp_st_ff;
   assign rsp_chan.count_after   = rsp_cnt_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_left_in   = rd_left_ff;
      dir_dn_in    = dir_dn_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      cap_in       = cap_ff;
      fin_wr_in    = fin_wr_ff;
      fin_addr_in  = fin_addr_ff;
      value_in     = value_ff;
      removed_in   = removed_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_rm_in    = rsp_rm_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      mem_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               removed_in = '0;
               value_in   = req_chan.value;
               fin_wr_in  = 1'b0;
               cap_in     = 1'b0;
               pend_in    = 1'b0;
               rd_left_in = '0;
               status_in  = ribi_pkg::STATUS_OK;
               state_in   = ST_MOVE;
               if (req_chan.func == ribi_pkg::FUNC_INSERT) begin
                  if (count_ff == ribi_pkg::CNT_FULL) begin
                     status_in = ribi_pkg::STATUS_FULL;
                     state_in  = ST_OUT;
                  end else if (idx > count_ff) begin
                     status_in = ribi_pkg::STATUS_RANGE;
                     state_in  = ST_OUT;
                  end else if (idx >= (count_ff >> 1)) begin
                     // Back side moves up by one slot, starting from the tail.
                     rd_ptr_in   = ribi_pkg::ptr_add(ribi_pkg::ptr_add(head_ff, count_ff),
                                                     ribi_pkg::STEP_DN);
                     rd_left_in  = count_ff - idx;
                     dir_dn_in   = 1'b1;
                     fin_wr_in   = 1'b1;
                     fin_addr_in = head_idx;
                     count_in    = count_ff + ribi_pkg::STEP_UP;
                  end else begin
                     // Front side moves down into the slot before the old head.
                     rd_ptr_in   = head_ff;
                     rd_left_in  = idx;
                     dir_dn_in   = 1'b0;
                     fin_wr_in   = 1'b1;
                     fin_addr_in = ribi_pkg::ptr_add(head_dn, idx);
                     head_in     = head_dn;
                     count_in    = count_ff + ribi_pkg::STEP_UP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ribi_pkg::STATUS_EMPTY;
                     state_in  = ST_OUT;
                  end else if (idx >= count_ff) begin
                     status_in = ribi_pkg::STATUS_RANGE;
                     state_in  = ST_OUT;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = head_idx;
                     cap_in          = 1'b1;
                     count_in        = cnt_m1;
                     if (idx >= (cnt_m1 >> 1)) begin
                        rd_ptr_in  = ribi_pkg::ptr_add(head_idx, ribi_pkg::STEP_UP);
                        rd_left_in = cnt_m1 - idx;
                        dir_dn_in  = 1'b0;
                     end else begin
                        rd_ptr_in  = ribi_pkg::ptr_add(head_idx, ribi_pkg::STEP_DN);
                        rd_left_in = idx;
                        dir_dn_in  = 1'b1;
                        head_in    = ribi_pkg::ptr_add(head_ff, ribi_pkg::STEP_UP);
                     end
                  end
               end
            end
         end

         ST_MOVE: begin
            // Each cycle writes the byte read in the previous one and issues the
            // next read, so one slot moves per cycle.
            if (pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pend_addr_ff;
               mem_req.wr_data = rd_data;
            end
            if (cap_ff) begin
               removed_in = rd_data;
               cap_in     = 1'b0;
            end
            if (rd_left_ff != '0) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_ptr_ff;
               pend_in         = 1'b1;
               rd_left_in      = rd_left_ff - ribi_pkg::STEP_UP;
               if (dir_dn_ff) begin
                  pend_addr_in = ribi_pkg::ptr_add(rd_ptr_ff, ribi_pkg::STEP_UP);
                  rd_ptr_in    = ribi_pkg::ptr_add(rd_ptr_ff, ribi_pkg::STEP_DN);
               end else begin
                  pend_addr_in = ribi_pkg::ptr_add(rd_ptr_ff, ribi_pkg::STEP_DN);
                  rd_ptr_in    = ribi_pkg::ptr_add(rd_ptr_ff, ribi_pkg::STEP_UP);
               end
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_FINAL;
               end
            end
         end

         ST_FINAL: begin
            if (fin_wr_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = fin_addr_ff;
               mem_req.wr_data = value_ff;
            end
            state_in = ST_OUT;
         end

         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_rm_in    = removed_ff;
               rsp_st_in    = status_ff;
               rsp_cnt_in   = count_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rd_left_ff   <= '0;
         pend_ff      <= 1'b0;
         cap_ff       <= 1'b0;
         fin_wr_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rd_left_ff   <= rd_left_in;
         pend_ff      <= pend_in;
         cap_ff       <= cap_in;
         fin_wr_ff    <= fin_wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      dir_dn_ff    <= dir_dn_in;
      pend_addr_ff <= pend_addr_in;
      fin_addr_ff  <= fin_addr_in;
      value_ff     <= value_in;
      removed_ff   <= removed_in;
      status_ff    <= status_in;
      rsp_rm_ff    <= rsp_rm_in;
      rsp_st_ff    <= rsp_st_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ribi_pkg::CNT_FULL)
      else $error("element count exceeds the ring capacity");

   a_short_side: assert property (@(posedge clock) disable iff (reset)
      rd_left_ff <= CNT_W'(ribi_pkg::CAPACITY / 2))
      else $error("shift longer than half the ring: wrong side chosen");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en && mem_req.rd_en |-> mem_req.wr_addr != mem_req.rd_addr)
      else $error("slot read and written in the same cycle");

   a_count_steady: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOVE |=> $stable(count_ff) && $stable(head_ff))
      else $error("head or count changed while slots were moving");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_ff && !cap_ff)
      else $error("move left pending on return to idle");

endmodule

[dv/ribi_ring_checker.sv]
`timescale 1ns / 100ps

module ribi_ring_checker
   import ribi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   ribi_req_if              req_chan,
   ribi_rsp_if              rsp_chan,
   output int unsigned      mismatch_count,
   output int unsigned      awaited_count,
   output logic [CNT_W-1:0] ring_fill
);

   typedef struct packed {
      logic [DATA_W-1:0]   removed;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    fill;
   } ring_reply_type;

   logic [DATA_W-1:0] ring_mem [CAPACITY];
   logic [PTR_W-1:0]  ring_head;
   ring_reply_type    reply_q [$];
   int unsigned       reply_seq;

   function automatic logic [PTR_W-1:0] slot_at(input int k);
      return PTR_W'((int'(ring_head) + k) % CAPACITY);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ring check: %s", $time, what);
   endtask

   // Applies one request to the ring copy and works out its response.
   task automatic apply_request(input logic func, input int idx,
                                input logic [DATA_W-1:0] val, output ring_reply_type reply);
      int n;
      int k;
      n = int'(ring_fill);
      reply = '0;
      reply.status = STATUS_OK;
      if (func == FUNC_INSERT) begin
         if (n >= CAPACITY) begin
            reply.status = STATUS_FULL;
         end else if (idx > n) begin
            reply.status = STATUS_RANGE;
         end else begin
            if (idx >= n / 2) begin
               for (k = n; k > idx; k--) begin
                  ring_mem[slot_at(k)] = ring_mem[slot_at(k - 1)];
               end
            end else begin
               // The front side moves down one slot, so the head steps back first.
               ring_head = PTR_W'((int'(ring_head) + CAPACITY - 1) % CAPACITY);
               for (k = 0; k < idx; k++) begin
                  ring_mem[slot_at(k)] = ring_mem[slot_at(k + 1)];
               end
            end
            ring_mem[slot_at(idx)] = val;
            n++;
         end
      end else begin
         if (n == 0) begin
            reply.status = STATUS_EMPTY;
         end else if (idx >= n) begin
            reply.status = STATUS_RANGE;
         end else begin
            reply.removed = ring_mem[slot_at(idx)];
            n--;
            if (idx >= n / 2) begin
               for (k = idx; k < n; k++) begin
                  ring_mem[slot_at(k)] = ring_mem[slot_at(k + 1)];
               end
            end else begin
               for (k = idx; k > 0; k--) begin
                  ring_mem[slot_at(k)] = ring_mem[slot_at(k - 1)];
               end
               ring_head = PTR_W'((int'(ring_head) + 1) % CAPACITY);
            end
         end
      end
      ring_fill  = CNT_W'(n);
      reply.fill = CNT_W'(n);
   endtask

   always @(posedge clock) begin : watch
      ring_reply_type want;
      if (reset) begin
         ring_head = '0;
         ring_fill = '0;
         for (int s = 0; s < CAPACITY; s++) begin
            ring_mem[s] = '0;
         end
         reply_q.delete();
         reply_seq      = 0;
         mismatch_count = 0;
         awaited_count  = 0;
      end else begin
         // A response can never belong to a request taken at the same edge.
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (reply_q.size() == 0) begin
               report_mismatch("response arrived with no request outstanding");
            end else begin
               want = reply_q.pop_front();
               if (rsp_chan.removed_value !== want.removed) begin
                  report_mismatch($sformatf("response %0d: removed_value %0h, expected %0h",
                                            reply_seq, rsp_chan.removed_value, want.removed));
               end
               if (rsp_chan.status !== want.status) begin
                  report_mismatch($sformatf("response %0d: status %0d, expected %0d",
                                            reply_seq, rsp_chan.status, want.status));
               end
               if (rsp_chan.count_after !== want.fill) begin
                  report_mismatch($sformatf("response %0d: count_after %0d, expected %0d",
                                            reply_seq, rsp_chan.count_after, want.fill));
               end
               reply_seq++;
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            apply_request(req_chan.func, int'(req_chan.index), req_chan.value, want);
            reply_q.push_back(want);
         end
         awaited_count = reply_q.size();
      end
   end

endmodule

[dv/tb_ring_buffer_indexed_insert_remove_top.sv]
`timescale 1ns / 100ps

module tb_ring_buffer_indexed_insert_remove_top;
   import ribi_pkg::*;

   localparam int RANDOM_REQUESTS = 1330;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int SETTLE_CYCLES   = 30;

   typedef enum logic [1:0] {FILL_UP, DRAIN_DOWN, CHURN} drift_type;

   logic        clock;
   logic        reset;
   int unsigned cycles;
   int unsigned mismatch_count;
   int unsigned awaited_count;
   logic [CNT_W-1:0] ring_fill;
   logic        steady_req;
   logic        steady_rsp;
   int          stall_left;

   ribi_req_if req_chan ();
   ribi_rsp_if rsp_chan ();

   ring_buffer_indexed_insert_remove_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ribi_ring_checker i_ring_check (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count),
      .ring_fill      (ring_fill)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #2 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_ring_buffer_indexed_insert_remove_top NOT OK");
         $finish;
      end
   end

   // Mostly short pauses, now and then a long one.
   function automatic int pause_length(input logic steady);
      int r;
      if (steady) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // The receiver stalls in bursts, with quiet stretches where it never stalls.
   initial begin
      rsp_chan.ready = 1'b0;
      stall_left = 0;
      steady_rsp = 1'b0;
      forever begin
         @(negedge clock);
         if (cycles % 500 == 0) begin
            steady_rsp <= ($urandom_range(0, 3) == 0);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!steady_rsp && $urandom_range(0, 99) < 25) begin
            stall_left = pause_length(1'b0);
            rsp_chan.ready <= (stall_left == 0);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge before the request goes out.
   task automatic idle_gap();
      int gap;
      gap = pause_length(steady_req);
      repeat (gap) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   // Presents one request and returns at the falling edge after it is taken.
   task automatic present(input logic func, input logic [CNT_W-1:0] idx,
                          input logic [DATA_W-1:0] val);
      req_chan.valid <= 1'b1;
      req_chan.func  <= func;
      req_chan.index <= idx;
      req_chan.value <= val;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   initial begin
      drift_type        drift;
      int               fill;
      logic             func;
      logic [CNT_W-1:0] idx;

      cycles         = 0;
      steady_req     = 1'b0;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func  = FUNC_INSERT;
      req_chan.index = '0;
      req_chan.value = '0;
      repeat (6) begin
         @(posedge clock);
      end
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: empty and range errors, both shift directions, head wrap.
      idle_gap(); present(FUNC_REMOVE, 5'd0, 8'h00);
      idle_gap(); present(FUNC_REMOVE, 5'd31, 8'hFF);
      idle_gap(); present(FUNC_INSERT, 5'd1, 8'h11);
      idle_gap(); present(FUNC_INSERT, 5'd0, 8'hFF);
      idle_gap(); present(FUNC_INSERT, 5'd1, 8'h00);
      idle_gap(); present(FUNC_INSERT, 5'd0, 8'hA5);
      idle_gap(); present(FUNC_INSERT, 5'd1, 8'h5A);
      idle_gap(); present(FUNC_INSERT, 5'd4, 8'h81);
      idle_gap(); present(FUNC_INSERT, 5'd6, 8'h7E);
      idle_gap(); present(FUNC_INSERT, 5'd31, 8'h3C);
      idle_gap(); present(FUNC_REMOVE, 5'd5, 8'h00);
      idle_gap(); present(FUNC_REMOVE, 5'd31, 8'h00);
      idle_gap(); present(FUNC_REMOVE, 5'd0, 8'h00);
      idle_gap(); present(FUNC_REMOVE, 5'd3, 8'h00);
      idle_gap(); present(FUNC_REMOVE, 5'd1, 8'h00);
      idle_gap(); present(FUNC_INSERT, 5'd16, 8'hC3);
      idle_gap(); present(FUNC_REMOVE, 5'd1, 8'h00);
      idle_gap(); present(FUNC_REMOVE, 5'd0, 8'h00);
      idle_gap(); present(FUNC_REMOVE, 5'd0, 8'h00);

      // Random part: drifts between filling, draining and churning so that the
      // full and empty corners are reached often.
      drift = FILL_UP;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 150 == 0) begin
            steady_req = ($urandom_range(0, 3) == 0);
         end
         idle_gap();
         fill = int'(ring_fill);
         if (fill >= CAPACITY && drift == FILL_UP && $urandom_range(0, 3) == 0) begin
            drift = DRAIN_DOWN;
         end else if (fill == 0 && drift == DRAIN_DOWN && $urandom_range(0, 3) == 0) begin
            drift = FILL_UP;
         end else if ($urandom_range(0, 63) == 0) begin
            drift = drift_type'($urandom_range(0, 2));
         end
         case (drift)
            FILL_UP: begin
               func = ($urandom_range(0, 99) < 80) ? FUNC_INSERT : FUNC_REMOVE;
            end
            DRAIN_DOWN: begin
               func = ($urandom_range(0, 99) < 20) ? FUNC_INSERT : FUNC_REMOVE;
            end
            default: begin
               func = ($urandom_range(0, 1) == 0) ? FUNC_INSERT : FUNC_REMOVE;
            end
         endcase
         if ($urandom_range(0, 99) < 12) begin
            idx = CNT_W'($urandom_range(0, 31));
         end else if (func == FUNC_INSERT) begin
            idx = CNT_W'($urandom_range(0, fill));
         end else begin
            idx = (fill > 0) ? CNT_W'($urandom_range(0, fill - 1)) : '0;
         end
         present(func, idx, DATA_W'($urandom_range(0, 255)));
      end
      req_chan.valid <= 1'b0;

      while (awaited_count != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) begin
         @(negedge clock);
      end
      if (mismatch_count == 0) begin
         $display("tb_ring_buffer_indexed_insert_remove_top OK");
      end else begin
         $display("tb_ring_buffer_indexed_insert_remove_top NOT OK");
      end
      $finish;
   end

endmodule
